// ===== rtl/fdrh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrh_pkg
// Shared types and constants of the flood dedup / rate / hop filter.
// ----------------------------------------------------------------------------
package fdrh_pkg;

    localparam int CACHE_DEPTH = 16;
    localparam int NUM_FACES   = 16;
    localparam int IDX_W       = $clog2(CACHE_DEPTH);

    localparam int ID_W     = 64;
    localparam int FACE_W   = 4;
    localparam int HOP_W    = 8;
    localparam int TIME_W   = 32;
    localparam int MASK_W   = 16;
    localparam int RATE_W   = 16;
    localparam int VERD_W   = 3;

    localparam int IN_DATA_W  = 112;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 4;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [MASK_W-1:0] FACE_LIMIT =
        (NUM_FACES >= MASK_W) ? {MASK_W{1'b1}}
                              : MASK_W'((64'd1 << NUM_FACES) - 64'd1);

    typedef enum logic [2:0] {
        REG_RATE_LIMIT  = 3'd0,
        REG_RATE_WINDOW = 3'd1,
        REG_DEDUP_AGE   = 3'd2,
        REG_DEF_HOP     = 3'd3,
        REG_FACE_UP     = 3'd4
    } reg_idx_t;

    typedef enum logic [VERD_W-1:0] {
        VERDICT_MISSING   = 3'd0,
        VERDICT_DUPLICATE = 3'd1,
        VERDICT_RATE      = 3'd2,
        VERDICT_HOP       = 3'd3,
        VERDICT_FLOOD     = 3'd4
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [RATE_W-1:0] rate_limit;
        logic [TIME_W-1:0] rate_window_ms;
        logic [TIME_W-1:0] dedup_age_ms;
        logic [HOP_W-1:0]  default_hop_limit;
        logic [MASK_W-1:0] face_up_mask;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic present;
        logic scan_last;
    } dp_stat_t;

endpackage

// ===== rtl/fdrh_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrh_regs
// Configuration register file behind the APB port.
// ----------------------------------------------------------------------------
module fdrh_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fdrh_pkg::PADDR_W-1:0]   paddr,
    input  logic [fdrh_pkg::PDATA_W-1:0]   pwdata,
    output logic [fdrh_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output fdrh_pkg::cfg_t                 cfg
);

    fdrh_pkg::cfg_t   cfg_reg;
    fdrh_pkg::reg_idx_t sel;
    logic             wr_en;

    assign pready = 1'b1;
    assign sel    = fdrh_pkg::reg_idx_t'(paddr[fdrh_pkg::PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate_limit        <= 16'd100;
            cfg_reg.rate_window_ms    <= 32'd1000;
            cfg_reg.dedup_age_ms      <= 32'd5000;
            cfg_reg.default_hop_limit <= 8'd3;
            cfg_reg.face_up_mask      <= 16'd0;
        end
        else if (wr_en)
        begin
            unique case (sel)
                fdrh_pkg::REG_RATE_LIMIT:  cfg_reg.rate_limit <= pwdata[15:0];
                fdrh_pkg::REG_RATE_WINDOW: cfg_reg.rate_window_ms <= pwdata;
                fdrh_pkg::REG_DEDUP_AGE:   cfg_reg.dedup_age_ms <= pwdata;
                fdrh_pkg::REG_DEF_HOP:     cfg_reg.default_hop_limit <= pwdata[7:0];
                fdrh_pkg::REG_FACE_UP:     cfg_reg.face_up_mask <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            fdrh_pkg::REG_RATE_LIMIT:  prdata = {16'd0, cfg_reg.rate_limit};
            fdrh_pkg::REG_RATE_WINDOW: prdata = cfg_reg.rate_window_ms;
            fdrh_pkg::REG_DEDUP_AGE:   prdata = cfg_reg.dedup_age_ms;
            fdrh_pkg::REG_DEF_HOP:     prdata = {24'd0, cfg_reg.default_hop_limit};
            fdrh_pkg::REG_FACE_UP:     prdata = {16'd0, cfg_reg.face_up_mask};
            default:                   prdata = '0;
        endcase
    end

endmodule

// ===== rtl/fdrh_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrh_ctrl
// Sequencer: accept, cache scan, commit, hand result to the output register.
// ----------------------------------------------------------------------------
module fdrh_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  fdrh_pkg::dp_stat_t  stat,
    output fdrh_pkg::dp_cmd_t   cmd
);

    fdrh_pkg::state_t state_reg;
    fdrh_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fdrh_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            fdrh_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = fdrh_pkg::ST_SCAN;
                end
            end
            fdrh_pkg::ST_SCAN:
            begin
                if (!stat.present)
                    state_next = fdrh_pkg::ST_EMIT;
                else
                begin
                    cmd.step = 1'b1;
                    if (stat.scan_last)
                        state_next = fdrh_pkg::ST_COMMIT;
                end
            end
            fdrh_pkg::ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = fdrh_pkg::ST_EMIT;
            end
            fdrh_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = fdrh_pkg::ST_IDLE;
                end
            end
            default: state_next = fdrh_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/fdrh_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrh_dp
// Datapath: id cache with purge and replacement, rate window, result forming.
// ----------------------------------------------------------------------------
module fdrh_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  fdrh_pkg::cfg_t                    cfg,
    input  fdrh_pkg::dp_cmd_t                 cmd,
    output fdrh_pkg::dp_stat_t                stat,
    input  logic [fdrh_pkg::ID_W-1:0]         flood_id,
    input  logic                              fields_present,
    input  logic [fdrh_pkg::FACE_W-1:0]       ingress_face,
    input  logic                              hop_tag_present,
    input  logic [fdrh_pkg::HOP_W-1:0]        hop_tag,
    input  logic [fdrh_pkg::TIME_W-1:0]       now_ms,
    output logic [fdrh_pkg::VERD_W-1:0]       verdict,
    output logic                              path_update,
    output logic [fdrh_pkg::MASK_W-1:0]       out_face_mask,
    output logic [fdrh_pkg::HOP_W-1:0]        out_hop_limit
);

    localparam int D = fdrh_pkg::CACHE_DEPTH;
    localparam int W = fdrh_pkg::IDX_W;

    logic [fdrh_pkg::ID_W-1:0]   cache_ids_reg    [D];
    logic [fdrh_pkg::TIME_W-1:0] cache_stamps_reg [D];
    logic [D-1:0]                cache_valid_reg;
    logic [D-1:0]                stale_reg;

    logic [fdrh_pkg::ID_W-1:0]   id_reg;
    logic                        present_reg;
    logic [fdrh_pkg::FACE_W-1:0] face_reg;
    logic                        tag_present_reg;
    logic [fdrh_pkg::HOP_W-1:0]  tag_reg;
    logic [fdrh_pkg::TIME_W-1:0] now_reg;

    logic [W-1:0]                idx_reg;
    logic                        hit_reg;
    logic                        free_found_reg;
    logic [W-1:0]                free_idx_reg;
    logic [W-1:0]                oldest_idx_reg;
    logic [fdrh_pkg::TIME_W-1:0] oldest_age_reg;

    logic [fdrh_pkg::RATE_W-1:0] window_count_reg;
    logic [fdrh_pkg::TIME_W-1:0] window_start_reg;

    fdrh_pkg::verdict_t          res_verdict_reg;
    logic                        res_update_reg;
    logic [fdrh_pkg::MASK_W-1:0] res_mask_reg;
    logic [fdrh_pkg::HOP_W-1:0]  res_hop_reg;

    fdrh_pkg::verdict_t          out_verdict_reg;
    logic                        out_update_reg;
    logic [fdrh_pkg::MASK_W-1:0] out_mask_reg;
    logic [fdrh_pkg::HOP_W-1:0]  out_hop_reg;

    logic                        e_valid;
    logic [fdrh_pkg::TIME_W-1:0] e_age;
    logic                        e_match;
    logic                        e_stale;
    logic                        e_free;
    logic [W-1:0]                slot;
    logic [fdrh_pkg::TIME_W-1:0] win_elapsed;
    logic                        win_expired;
    logic [fdrh_pkg::RATE_W-1:0] cnt_eff;

    assign stat.present   = present_reg;
    assign stat.scan_last = (idx_reg == W'(D - 1));

    assign e_valid = cache_valid_reg[idx_reg];
    assign e_age   = now_reg - cache_stamps_reg[idx_reg];
    assign e_match = e_valid && (cache_ids_reg[idx_reg] == id_reg);
    assign e_stale = e_valid && (e_age > cfg.dedup_age_ms);
    assign e_free  = !e_valid || e_stale;

    assign slot        = free_found_reg ? free_idx_reg : oldest_idx_reg;
    assign win_elapsed = now_reg - window_start_reg;
    assign win_expired = win_elapsed > cfg.rate_window_ms;
    assign cnt_eff     = win_expired ? '0 : window_count_reg;

    // item capture and scan bookkeeping
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg          <= flood_id;
            present_reg     <= fields_present;
            face_reg        <= ingress_face;
            tag_present_reg <= hop_tag_present;
            tag_reg         <= hop_tag;
            now_reg         <= now_ms;
            idx_reg         <= '0;
            hit_reg         <= 1'b0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            oldest_idx_reg  <= '0;
            oldest_age_reg  <= '0;
        end
        else if (cmd.step)
        begin
            idx_reg            <= idx_reg + 1'b1;
            hit_reg            <= hit_reg || e_match;
            stale_reg[idx_reg] <= e_stale;
            if (e_free && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= idx_reg;
            end
            if (!e_free && ((idx_reg == '0) || (e_age > oldest_age_reg)))
            begin
                oldest_idx_reg <= idx_reg;
                oldest_age_reg <= e_age;
            end
        end
    end

    // cache payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !hit_reg)
        begin
            cache_ids_reg[slot]    <= id_reg;
            cache_stamps_reg[slot] <= now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_valid_reg  <= '0;
            window_count_reg <= '0;
            window_start_reg <= '0;
        end
        else if (cmd.commit && !hit_reg)
        begin
            for (int i = 0; i < D; i++)
                cache_valid_reg[i] <= (cache_valid_reg[i] && !stale_reg[i])
                                      || (slot == W'(i));
            if (win_expired)
                window_start_reg <= now_reg;
            if (cnt_eff >= cfg.rate_limit)
                window_count_reg <= cnt_eff;
            else
                window_count_reg <= cnt_eff + 1'b1;
        end
    end

    // result forming
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_verdict_reg <= fdrh_pkg::VERDICT_MISSING;
            res_update_reg  <= 1'b0;
            res_mask_reg    <= '0;
            res_hop_reg     <= '0;
        end
        else if (cmd.commit)
        begin
            if (hit_reg)
            begin
                res_verdict_reg <= fdrh_pkg::VERDICT_DUPLICATE;
                res_update_reg  <= 1'b0;
                res_mask_reg    <= '0;
                res_hop_reg     <= '0;
            end
            else if (cnt_eff >= cfg.rate_limit)
            begin
                res_verdict_reg <= fdrh_pkg::VERDICT_RATE;
                res_update_reg  <= 1'b1;
                res_mask_reg    <= '0;
                res_hop_reg     <= '0;
            end
            else if (tag_present_reg && (tag_reg == '0))
            begin
                res_verdict_reg <= fdrh_pkg::VERDICT_HOP;
                res_update_reg  <= 1'b1;
                res_mask_reg    <= '0;
                res_hop_reg     <= '0;
            end
            else
            begin
                res_verdict_reg <= fdrh_pkg::VERDICT_FLOOD;
                res_update_reg  <= 1'b1;
                res_mask_reg    <= cfg.face_up_mask & fdrh_pkg::FACE_LIMIT
                                   & ~(fdrh_pkg::MASK_W'(1) << face_reg);
                res_hop_reg     <= tag_present_reg ? tag_reg - 1'b1
                                                   : cfg.default_hop_limit;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_verdict_reg <= res_verdict_reg;
            out_update_reg  <= res_update_reg;
            out_mask_reg    <= res_mask_reg;
            out_hop_reg     <= res_hop_reg;
        end
    end

    assign verdict       = out_verdict_reg;
    assign path_update   = out_update_reg;
    assign out_face_mask = out_mask_reg;
    assign out_hop_limit = out_hop_reg;

endmodule

// ===== rtl/flood_dedup_rate_hop_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flood_dedup_rate_hop_filter_unit
// Flood filter: missing-field drop, duplicate suppression, rate and hop limit.
// ----------------------------------------------------------------------------
// Steps: accept and capture the input beat, a 16-step cache scan (one entry
// a cycle), commit, output load; a packet without its fields skips the scan
// steps and commit, and output load waits while the output beat is stalled.
// One item is processed at a time, one more may wait in the output register.
// Reset: asynchronous, clears cache valid bits, rate window, controller state
// and output valid, and loads config defaults; datapath data is not reset.
module flood_dedup_rate_hop_filter_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    // tdata: flood_id[63:0], ingress_face[67:64], hop_tag[75:68],
    //        now_ms[107:76], zero pad
    input  logic [fdrh_pkg::IN_DATA_W-1:0]      s_tdata,
    // tuser: fields_present[0], hop_tag_present[1]
    input  logic [fdrh_pkg::IN_USER_W-1:0]      s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: out_face_mask[15:0], out_hop_limit[23:16]
    output logic [fdrh_pkg::OUT_DATA_W-1:0]     m_tdata,
    // tuser: verdict[2:0], path_update[3]
    output logic [fdrh_pkg::OUT_USER_W-1:0]     m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fdrh_pkg::PADDR_W-1:0]        paddr,
    input  logic [fdrh_pkg::PDATA_W-1:0]        pwdata,
    output logic [fdrh_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    fdrh_pkg::cfg_t              cfg;
    fdrh_pkg::dp_cmd_t           cmd;
    fdrh_pkg::dp_stat_t          stat;
    logic [fdrh_pkg::VERD_W-1:0] verdict;
    logic                        path_update;
    logic [fdrh_pkg::MASK_W-1:0] out_face_mask;
    logic [fdrh_pkg::HOP_W-1:0]  out_hop_limit;

    fdrh_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fdrh_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fdrh_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .stat            (stat),
        .flood_id        (s_tdata[63:0]),
        .fields_present  (s_tuser[0]),
        .ingress_face    (s_tdata[67:64]),
        .hop_tag_present (s_tuser[1]),
        .hop_tag         (s_tdata[75:68]),
        .now_ms          (s_tdata[107:76]),
        .verdict         (verdict),
        .path_update     (path_update),
        .out_face_mask   (out_face_mask),
        .out_hop_limit   (out_hop_limit)
    );

    assign m_tdata = {out_hop_limit, out_face_mask};
    assign m_tuser = {path_update, verdict};

endmodule

// ===== rtl/fdrh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdrh_checker
// Port-level checks of the flood filter, bound to the top level.
// ----------------------------------------------------------------------------
module fdrh_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic [fdrh_pkg::OUT_DATA_W-1:0]      m_tdata,
    input logic [fdrh_pkg::OUT_USER_W-1:0]      m_tuser,
    input logic                                 m_tvalid,
    input logic                                 m_tready
);

    logic [fdrh_pkg::VERD_W-1:0] v;
    assign v = m_tuser[2:0];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> v <= fdrh_pkg::VERDICT_FLOOD)
        else $error("verdict out of range");

    a_zero_unless_flood: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (v != fdrh_pkg::VERDICT_FLOOD) |-> m_tdata == '0)
        else $error("mask or hop set without flood verdict");

    a_path_update: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[3] == (v == fdrh_pkg::VERDICT_RATE
                                    || v == fdrh_pkg::VERDICT_HOP
                                    || v == fdrh_pkg::VERDICT_FLOOD))
        else $error("path update inconsistent with verdict");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while item in flight");

endmodule

bind flood_dedup_rate_hop_filter_unit fdrh_checker u_fdrh_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
